// File: sv/isst_pkg.sv
package isst_pkg;

    localparam int DEF_MAX_RANGES = 64;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] left;
        logic [31:0] right;
    } req_t;

    typedef struct packed {
        logic       covered;
        logic [1:0] status;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic cnt_step;
        logic clr_idx;
        logic bld_step;
        logic commit;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic idx_done;
        logic no_build;
    } sts_t;

endpackage

// File: sv/interval_set_tracker.sv
// channel   signals              handshake
// request   start, req           taken when start && !busy
// result    done, rsp            valid for the single cycle done is high
//
// Add and remove make a count pass and a rebuild pass over the table, each
// visiting every entry in a read state and an evaluate state through the
// registered RAM read, plus extra visits for an insert or a split; query,
// invalid and overflowing requests make only the count pass.
// Reset empties the table at once; no clearing pass is needed.
// The result cannot be stalled; a new request may start while done is high.
module interval_set_tracker #(
    parameter int MAX_RANGES = isst_pkg::DEF_MAX_RANGES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  isst_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output isst_pkg::rsp_t rsp
);
    import isst_pkg::*;

    cmd_t cmd;
    sts_t sts;

    isst_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
    );

    isst_dp #(.MAX_RANGES(MAX_RANGES)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd), .sts(sts),
        .done(done), .rsp(rsp)
    );

    // result follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without request");
    // result lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result repeated");
    // coverage only on successful query
    assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.covered |-> rsp.status == ST_OK)
        else $error("covered with error status");
    // accepted request makes block busy
    assert property (@(posedge clk) disable iff (!rst_n) start && !busy |=> busy)
        else $error("request dropped");

endmodule

// File: sv/isst_ram.sv
module isst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/isst_ctrl.sv
module isst_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  isst_pkg::sts_t sts,
    output isst_pkg::cmd_t cmd,
    output logic          busy
);
    import isst_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CNT_RD = 3'd1;
    localparam logic [2:0] S_CNT_EV = 3'd2;
    localparam logic [2:0] S_CHK    = 3'd3;
    localparam logic [2:0] S_BLD_RD = 3'd4;
    localparam logic [2:0] S_BLD_EV = 3'd5;
    localparam logic [2:0] S_CMT    = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0] state_reg, state_next;

    // sequence count pass, check, build pass, commit, finish
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CNT_RD;
                end
            end
            S_CNT_RD:
            begin
                state_next = sts.idx_done ? S_CHK : S_CNT_EV;
            end
            S_CNT_EV:
            begin
                cmd.cnt_step = 1'b1;
                state_next   = S_CNT_RD;
            end
            S_CHK:
            begin
                cmd.clr_idx = 1'b1;
                state_next  = sts.no_build ? S_FIN : S_BLD_RD;
            end
            S_BLD_RD:
            begin
                state_next = sts.idx_done ? S_CMT : S_BLD_EV;
            end
            S_BLD_EV:
            begin
                cmd.bld_step = 1'b1;
                state_next   = S_BLD_RD;
            end
            S_CMT:
            begin
                cmd.commit = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: sv/isst_dp.sv
module isst_dp #(
    parameter int MAX_RANGES = isst_pkg::DEF_MAX_RANGES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  isst_pkg::req_t req,
    input  isst_pkg::cmd_t cmd,
    output isst_pkg::sts_t sts,
    output logic           done,
    output isst_pkg::rsp_t rsp
);
    import isst_pkg::*;

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW+1:0] MAX_V = (CW+2)'(MAX_RANGES);

    logic [1:0]    func_reg;
    logic [31:0]   l_reg, r_reg;
    logic          bank_reg, bank_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW:0]   acc_reg, acc_next;
    logic          hit_reg, hit_next;
    logic          placed_reg, placed_next;
    logic          phase_reg, phase_next;
    logic [31:0]   ms_reg, ms_next, me_reg, me_next;
    logic          full_reg;
    logic          done_reg;
    rsp_t          rsp_reg;

    logic [63:0] rd0, rd1, rdata, wdata;
    logic        we;
    logic [31:0] s, e;
    logic        invalid, full, ovl_add, out_rem;

    // both banks share address; the other bank takes writes
    isst_ram #(.WIDTH(64), .DEPTH(MAX_RANGES)) u_ram0 (
        .clk(clk), .we(we & bank_reg), .waddr(n_reg[AW-1:0]), .wdata(wdata),
        .raddr(idx_reg[AW-1:0]), .rdata(rd0)
    );
    isst_ram #(.WIDTH(64), .DEPTH(MAX_RANGES)) u_ram1 (
        .clk(clk), .we(we & ~bank_reg), .waddr(n_reg[AW-1:0]), .wdata(wdata),
        .raddr(idx_reg[AW-1:0]), .rdata(rd1)
    );

    assign rdata = bank_reg ? rd1 : rd0;
    assign s     = rdata[63:32];
    assign e     = rdata[31:0];

    assign invalid = (l_reg >= r_reg) || (func_reg == 2'd3);
    assign ovl_add = (e >= l_reg) && (s <= r_reg);
    assign out_rem = (e <= l_reg) || (s >= r_reg);

    // overflow check from count pass
    always_comb
    begin
        full = 1'b0;
        if (func_reg == FUNC_ADD)
        begin
            full = ({2'b0, count_reg} + (CW+2)'(1)) > ({1'b0, acc_reg} + MAX_V);
        end
        else if (func_reg == FUNC_REMOVE)
        begin
            full = {1'b0, acc_reg} > MAX_V;
        end
    end

    assign sts.idx_done = (idx_reg == count_reg);
    assign sts.no_build = invalid || full || (func_reg == FUNC_QUERY);

    // count pass, build pass and commit
    always_comb
    begin
        bank_next   = bank_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        acc_next    = acc_reg;
        hit_next    = hit_reg;
        placed_next = placed_reg;
        phase_next  = phase_reg;
        ms_next     = ms_reg;
        me_next     = me_reg;
        we          = 1'b0;
        wdata       = rdata;
        if (cmd.load)
        begin
            idx_next    = '0;
            acc_next    = '0;
            hit_next    = 1'b0;
            placed_next = 1'b0;
            phase_next  = 1'b0;
            ms_next     = req.left;
            me_next     = req.right;
        end
        if (cmd.cnt_step)
        begin
            idx_next = idx_reg + 1'b1;
            if (func_reg == FUNC_ADD)
            begin
                acc_next = acc_reg + (CW+1)'(ovl_add);
            end
            else if (out_rem)
            begin
                acc_next = acc_reg + 1'b1;
            end
            else
            begin
                acc_next = acc_reg + (CW+1)'(s < l_reg) + (CW+1)'(e > r_reg);
            end
            if ((s <= l_reg) && (e >= r_reg))
            begin
                hit_next = 1'b1;
            end
        end
        if (cmd.clr_idx)
        begin
            idx_next = '0;
            n_next   = '0;
        end
        if (cmd.bld_step)
        begin
            if (func_reg == FUNC_ADD)
            begin
                if (e < l_reg)
                begin
                    we       = 1'b1;
                    n_next   = n_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (s > r_reg)
                begin
                    we     = 1'b1;
                    n_next = n_reg + 1'b1;
                    if (!placed_reg)
                    begin
                        // insert merged range, revisit this entry
                        wdata       = {ms_reg, me_reg};
                        placed_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (s < ms_reg)
                    begin
                        ms_next = s;
                    end
                    if (e > me_reg)
                    begin
                        me_next = e;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            else
            begin
                if (out_rem)
                begin
                    we       = 1'b1;
                    n_next   = n_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!phase_reg && (s < l_reg))
                begin
                    // left piece; right piece on a second visit
                    we     = 1'b1;
                    wdata  = {s, l_reg};
                    n_next = n_reg + 1'b1;
                    if (e > r_reg)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    we         = (e > r_reg);
                    wdata      = {r_reg, e};
                    n_next     = n_reg + CW'(e > r_reg);
                    phase_next = 1'b0;
                    idx_next   = idx_reg + 1'b1;
                end
            end
        end
        if (cmd.commit)
        begin
            if ((func_reg == FUNC_ADD) && !placed_reg)
            begin
                we         = 1'b1;
                wdata      = {ms_reg, me_reg};
                count_next = n_reg + 1'b1;
            end
            else
            begin
                count_next = n_reg;
            end
            bank_next = ~bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            bank_reg  <= bank_next;
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    // hold request and working values
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= req.func;
            l_reg    <= req.left;
            r_reg    <= req.right;
        end
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        acc_reg    <= acc_next;
        hit_reg    <= hit_next;
        placed_reg <= placed_next;
        phase_reg  <= phase_next;
        ms_reg     <= ms_next;
        me_reg     <= me_next;
        // hold the overflow verdict before commit changes the count
        if (cmd.clr_idx)
        begin
            full_reg <= full;
        end
        if (cmd.finish)
        begin
            rsp_reg.covered <= !invalid && (func_reg == FUNC_QUERY) && hit_reg;
            rsp_reg.status  <= invalid ? ST_INVALID : (full_reg ? ST_FULL : ST_OK);
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: bench/tb.sv
module tb;
    import isst_pkg::*;

    localparam int NRANGE = DEF_MAX_RANGES;

    int         mismatches;

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Table model and queue of pending responses
    class range_board;
        logic [31:0] starts[$];
        logic [31:0] ends[$];
        rsp_t        pending[$];
        int          errors;

        function void reset_table();
            starts.delete();
            ends.delete();
            pending.delete();
            errors = 0;
        endfunction

        // Apply one accepted request to the table and queue its response
        function void note_request(req_t r);
            rsp_t        o;
            logic [31:0] ns[$];
            logic [31:0] ne[$];
            logic [31:0] ms;
            logic [31:0] me;
            int          k;
            int          need;
            bit          placed;
            o.covered = 1'b0;
            o.status  = ST_OK;
            if (r.left >= r.right || r.func > FUNC_QUERY) begin
                o.status = ST_INVALID;
            end else if (r.func == FUNC_ADD) begin
                k = 0;
                foreach (starts[i])
                    if (!(ends[i] < r.left || starts[i] > r.right)) k++;
                if (starts.size() - k + 1 > NRANGE) begin
                    o.status = ST_FULL;
                end else begin
                    ms = r.left;
                    me = r.right;
                    placed = 0;
                    foreach (starts[i]) begin
                        if (ends[i] < r.left) begin
                            ns.push_back(starts[i]); ne.push_back(ends[i]);
                        end else if (starts[i] > r.right) begin
                            if (!placed) begin
                                ns.push_back(ms); ne.push_back(me); placed = 1;
                            end
                            ns.push_back(starts[i]); ne.push_back(ends[i]);
                        end else begin
                            if (starts[i] < ms) ms = starts[i];
                            if (ends[i] > me) me = ends[i];
                        end
                    end
                    if (!placed) begin
                        ns.push_back(ms); ne.push_back(me);
                    end
                    starts = ns;
                    ends = ne;
                end
            end else if (r.func == FUNC_REMOVE) begin
                need = 0;
                foreach (starts[i]) begin
                    if (ends[i] <= r.left || starts[i] >= r.right) need++;
                    else need += int'(starts[i] < r.left) + int'(ends[i] > r.right);
                end
                if (need > NRANGE) begin
                    o.status = ST_FULL;
                end else begin
                    foreach (starts[i]) begin
                        if (ends[i] <= r.left || starts[i] >= r.right) begin
                            ns.push_back(starts[i]); ne.push_back(ends[i]);
                        end else begin
                            if (starts[i] < r.left) begin
                                ns.push_back(starts[i]); ne.push_back(r.left);
                            end
                            if (ends[i] > r.right) begin
                                ns.push_back(r.right); ne.push_back(ends[i]);
                            end
                        end
                    end
                    starts = ns;
                    ends = ne;
                end
            end else begin
                foreach (starts[i])
                    if (starts[i] <= r.left && ends[i] >= r.right) o.covered = 1'b1;
            end
            pending.push_back(o);
        endfunction

        // Compare one response with the oldest expected one
        task check_response(rsp_t got);
            rsp_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected response %p", got));
                return;
            end
            want = pending.pop_front();
            if (got.covered !== want.covered)
                report_mismatch($sformatf("covered %b want %b", got.covered, want.covered));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    range_board board;
    int         gap_pct;

    interval_set_tracker u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Check responses at each edge
    always @(posedge clk)
    begin
        if (rst_n && done) board.check_response(rsp);
    end

    // Drive one request and hold it until accepted
    task automatic send_request(logic [1:0] f, logic [31:0] l, logic [31:0] r);
        req_t q;
        q.func = f;
        q.left = l;
        q.right = r;
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < gap_pct) @(posedge clk);
        end
        start <= 1'b1;
        req <= q;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_request(q);
    endtask

    // Small bounds keep ranges colliding; a few use the full span
    function automatic logic [31:0] pick_bound(int span);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(span);
            default: return $urandom_range(span);
        endcase
    endfunction

    task automatic random_phase(int count, int pct);
        logic [31:0] l;
        logic [31:0] r;
        logic [1:0]  f;
        int          span;
        gap_pct = pct;
        for (int n = 0; n < count; n++) begin
            span = ($urandom_range(3) == 0) ? 2000 : 300;
            l = pick_bound(span);
            r = ($urandom_range(15) == 0) ? pick_bound(span) : l + $urandom_range(1, 40);
            f = $urandom_range(15) == 0 ? 2'd3 : 2'($urandom_range(2));
            send_request(f, l, r);
        end
    endtask

    task automatic drain();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (board.pending.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
    endtask

    initial
    begin
        board = new();
        board.reset_table();
        mismatches = 0;
        gap_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, invalid, extremes, merge, split, overflow
        send_request(FUNC_QUERY, 32'd0, 32'd1);
        send_request(FUNC_REMOVE, 32'd5, 32'd9);
        send_request(FUNC_ADD, 32'd7, 32'd7);
        send_request(FUNC_ADD, 32'd9, 32'd3);
        send_request(2'd3, 32'd1, 32'd2);
        send_request(FUNC_ADD, 32'd0, 32'hFFFF_FFFF);
        send_request(FUNC_QUERY, 32'd0, 32'hFFFF_FFFF);
        send_request(FUNC_REMOVE, 32'h7FFF_FFFF, 32'h8000_0001);
        send_request(FUNC_QUERY, 32'h8000_0000, 32'h8000_0002);
        send_request(FUNC_REMOVE, 32'd0, 32'hFFFF_FFFF);
        send_request(FUNC_ADD, 32'd10, 32'd20);
        send_request(FUNC_ADD, 32'd20, 32'd30);
        send_request(FUNC_ADD, 32'd40, 32'd50);
        send_request(FUNC_ADD, 32'd25, 32'd45);
        send_request(FUNC_QUERY, 32'd10, 32'd50);
        send_request(FUNC_REMOVE, 32'd15, 32'd16);
        send_request(FUNC_QUERY, 32'd10, 32'd16);
        // Fill the table to the brim, then overflow by add, trim one entry and clear all
        for (int i = 0; i < NRANGE; i++)
            send_request(FUNC_ADD, 32'(1000 + 4 * i), 32'(1002 + 4 * i));
        send_request(FUNC_ADD, 32'd5000, 32'd5001);
        send_request(FUNC_REMOVE, 32'd1000, 32'd1001);
        send_request(FUNC_REMOVE, 32'd0, 32'hFFFF_FFFF);

        random_phase(320, 9);
        // Hold off until all responses are back
        drain();
        random_phase(350, 47);
        random_phase(350, 0);
        drain();
        repeat (300) @(posedge clk);

        if (mismatches == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: filelist.f
sv/isst_pkg.sv
sv/isst_ram.sv
sv/isst_ctrl.sv
sv/isst_dp.sv
sv/interval_set_tracker.sv
bench/tb.sv
